@@ rtl/core/abd_pkg.sv @@
package abd_pkg;

	localparam int unsigned TIME_W = 48;
	localparam int unsigned DUR_W  = 32;
	localparam int unsigned GROW_W = 8;
	localparam int unsigned CMD_W  = 2;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned CNT_W  = $clog2(TIME_W + 1);

	localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FEEDBACK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESET    = 2'd2;

	localparam logic [IDX_W-1:0] REG_MIN_DURATION = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_DURATION = 3'd1;
	localparam logic [IDX_W-1:0] REG_DECAY_AMOUNT = 3'd2;
	localparam logic [IDX_W-1:0] REG_DECAY_STEP   = 3'd3;
	localparam logic [IDX_W-1:0] REG_GROW_FACTOR  = 3'd4;

	localparam logic [DUR_W-1:0]  MIN_DURATION_RST = 32'd1000;
	localparam logic [DUR_W-1:0]  MAX_DURATION_RST = 32'd3600000;
	localparam logic [DUR_W-1:0]  DECAY_AMOUNT_RST = 32'd1000;
	localparam logic [DUR_W-1:0]  DECAY_STEP_RST   = 32'd60000;
	localparam logic [GROW_W-1:0] GROW_FACTOR_RST  = 8'd2;

	// Start request for the serial multiplier: how many multiplier bits to consume.
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] len;
	} mul_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ELAPSE,
		ST_HOLD,
		ST_DIV,
		ST_MUL,
		ST_DECAY,
		ST_APPLY,
		ST_GROW,
		ST_DONE
	} state_t;

endpackage

@@ rtl/core/abd_div.sv @@
module abd_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [abd_pkg::TIME_W-1:0] dividend,
	input  logic [abd_pkg::DUR_W-1:0]  divisor,
	output logic [abd_pkg::TIME_W-1:0] quotient,
	output logic                       done
);
	import abd_pkg::*;

	logic [TIME_W-1:0] quo_q;
	logic [DUR_W-1:0]  rem_q;
	logic [DUR_W-1:0]  dsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DUR_W+1:0]  trial;

	// Restoring division, one quotient bit per cycle; the quotient shifts in
	// behind the dividend bits as they are consumed.
	assign trial = {1'b0, rem_q, quo_q[TIME_W-1]} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TIME_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[TIME_W-2:0], ~trial[DUR_W+1]};
			if (!trial[DUR_W+1]) begin
				rem_q <= trial[DUR_W-1:0];
			end else begin
				rem_q <= {rem_q[DUR_W-2:0], quo_q[TIME_W-1]};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

@@ rtl/core/abd_mul.sv @@
module abd_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  abd_pkg::mul_cmd_t          cmd,
	input  logic [abd_pkg::DUR_W-1:0]  mcand,
	input  logic [abd_pkg::TIME_W-1:0] mplr,
	output logic [abd_pkg::DUR_W-1:0]  product,
	output logic                       ovf,
	output logic                       done
);
	import abd_pkg::*;

	logic [DUR_W-1:0]  acc_q;
	logic              ovf_q;
	logic [DUR_W-1:0]  mcand_q;
	logic [TIME_W-1:0] mplr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DUR_W+1:0]  sum;

	// Shift-add from the multiplier's top bit down. Once the partial product
	// leaves 32 bits it can only grow, so a sticky flag replaces the upper bits.
	assign sum = {1'b0, acc_q, 1'b0} + {2'b00, (mplr_q[TIME_W-1] ? mcand_q : '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.len;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			mcand_q <= mcand;
			mplr_q  <= mplr;
		end else if (busy_q) begin
			acc_q  <= sum[DUR_W-1:0];
			ovf_q  <= ovf_q | (sum[DUR_W+1:DUR_W] != 2'b00);
			mplr_q <= {mplr_q[TIME_W-2:0], 1'b0};
		end
	end

	assign product = acc_q;
	assign ovf     = ovf_q;
	assign done    = done_q;

endmodule

@@ rtl/core/adaptive_backoff_duration.sv @@
// Channel  Direction  Handshake            Payload
// in       inbound    in_valid / in_stall  cmd, now_ms, hold_ms
// out      outbound   out_valid / out_stall effective_ms, at_minimum
// cfg      inbound    cfg_we               cfg_index, cfg_data
//
// One item at a time. A query that falls within the hold skips the divider and the
// decay multiply; one past the hold runs the 48-bit serial divider and the 48-bit
// serial multiplier that scales the step count. Feedback adds the 8-bit growth
// multiply on the same multiplier.
// Reset restores the register defaults and clears the stored duration, stamp and hold.
// A result waits in the output register under out_stall while the next item is taken.
module adaptive_backoff_duration (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [abd_pkg::CMD_W-1:0]  cmd,
	input  logic [abd_pkg::TIME_W-1:0] now_ms,
	input  logic [abd_pkg::DUR_W-1:0]  hold_ms,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [abd_pkg::DUR_W-1:0]  effective_ms,
	output logic                       at_minimum,
	input  logic                       cfg_we,
	input  logic [abd_pkg::IDX_W-1:0]  cfg_index,
	input  logic [abd_pkg::DUR_W-1:0]  cfg_data
);
	import abd_pkg::*;

	state_t state_q, state_d;

	logic [DUR_W-1:0]  min_q, max_q, amount_q, step_q;
	logic [GROW_W-1:0] grow_q;

	logic [DUR_W-1:0]  stored_q;
	logic [TIME_W-1:0] stamp_q;
	logic [DUR_W-1:0]  hold_len_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [TIME_W-1:0] now_q;
	logic [DUR_W-1:0]  hold_q;
	logic [TIME_W-1:0] elapsed_q;
	logic              before_q;
	logic [DUR_W-1:0]  eff_q;

	logic              out_valid_q;
	logic [DUR_W-1:0]  out_eff_q;
	logic              out_min_q;

	logic              accept;
	logic              out_free;
	logic [TIME_W:0]   elapsed_full;
	logic [TIME_W:0]   over_full;
	logic              in_hold;
	logic [DUR_W:0]    decay_diff;
	logic [DUR_W-1:0]  decay_eff;
	logic [DUR_W-1:0]  reset_cap;
	logic [DUR_W-1:0]  reset_val;
	logic [DUR_W-1:0]  grow_val;

	logic              div_start;
	logic [DUR_W-1:0]  divisor;
	logic [TIME_W-1:0] quotient;
	logic              div_done;

	mul_cmd_t          mul_cmd;
	logic [DUR_W-1:0]  mul_mcand;
	logic [TIME_W-1:0] mul_mplr;
	logic [DUR_W-1:0]  product;
	logic              mul_ovf;
	logic              mul_done;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Elapsed time; the borrow marks a time earlier than the stamp.
	assign elapsed_full = {1'b0, now_q} - {1'b0, stamp_q};
	// The borrow here means the time is still within the hold.
	assign over_full = {1'b0, elapsed_q} - {{(TIME_W-DUR_W+1){1'b0}}, hold_len_q};
	assign in_hold   = before_q || over_full[TIME_W] || (over_full[TIME_W-1:0] == '0);

	// A borrow or overflow means the total decay exceeds the stored value.
	assign decay_diff = {1'b0, stored_q} - {1'b0, product};
	assign decay_eff  = (mul_ovf || decay_diff[DUR_W] || (decay_diff[DUR_W-1:0] < min_q))
		? min_q : decay_diff[DUR_W-1:0];

	assign reset_cap = (hold_q > max_q) ? max_q : hold_q;
	assign reset_val = (reset_cap < min_q) ? min_q : reset_cap;
	assign grow_val  = (mul_ovf || (product > max_q)) ? max_q : product;

	assign divisor = (step_q == '0) ? DUR_W'(1) : step_q;

	abd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (over_full[TIME_W-1:0]),
		.divisor  (divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	abd_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (mul_cmd),
		.mcand   (mul_mcand),
		.mplr    (mul_mplr),
		.product (product),
		.ovf     (mul_ovf),
		.done    (mul_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		div_start   = 1'b0;
		mul_cmd     = '0;
		mul_mcand   = amount_q;
		mul_mplr    = quotient;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_ELAPSE;
				end
			end
			ST_ELAPSE: begin
				state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (in_hold) begin
					state_d = ST_APPLY;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					mul_cmd.start = 1'b1;
					mul_cmd.len   = CNT_W'(TIME_W);
					state_d       = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					state_d = ST_DECAY;
				end
			end
			ST_DECAY: begin
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				priority if (cmd_q == CMD_FEEDBACK) begin
					mul_cmd.start = 1'b1;
					mul_cmd.len   = CNT_W'(GROW_W);
					mul_mcand     = eff_q;
					mul_mplr      = {grow_q, {(TIME_W-GROW_W){1'b0}}};
					state_d       = ST_GROW;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_GROW: begin
				if (mul_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration registers and the duration state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q      <= MIN_DURATION_RST;
			max_q      <= MAX_DURATION_RST;
			amount_q   <= DECAY_AMOUNT_RST;
			step_q     <= DECAY_STEP_RST;
			grow_q     <= GROW_FACTOR_RST;
			stored_q   <= '0;
			stamp_q    <= '0;
			hold_len_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MIN_DURATION: min_q    <= cfg_data;
					REG_MAX_DURATION: max_q    <= cfg_data;
					REG_DECAY_AMOUNT: amount_q <= cfg_data;
					REG_DECAY_STEP:   step_q   <= cfg_data;
					REG_GROW_FACTOR:  grow_q   <= cfg_data[GROW_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_APPLY && cmd_q == CMD_RESET) begin
				stored_q   <= reset_val;
				hold_len_q <= '0;
				stamp_q    <= now_q;
			end else if (state_q == ST_GROW && mul_done) begin
				stored_q   <= grow_val;
				hold_len_q <= hold_q;
				stamp_q    <= now_q;
			end
		end
	end

	// Item registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			now_q  <= now_ms;
			hold_q <= hold_ms;
		end
		if (state_q == ST_ELAPSE) begin
			elapsed_q <= elapsed_full[TIME_W-1:0];
			before_q  <= elapsed_full[TIME_W];
		end
		if (state_q == ST_HOLD && in_hold) begin
			eff_q <= stored_q;
		end
		if (state_q == ST_DECAY) begin
			eff_q <= decay_eff;
		end
		if (state_q == ST_DONE && out_free) begin
			out_eff_q <= eff_q;
			out_min_q <= (eff_q == min_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign effective_ms = out_eff_q;
	assign at_minimum   = out_min_q;

endmodule
